[hw/rtl/flc_pkg.sv]
// shared types and codes of the flow usage counter table
package flc_pkg;

    // slot index width, sized for a table of up to 64 slots
    localparam int IDX_W = 6;

    // operation codes
    localparam logic [2:0] OP_UPDATE = 3'd0;
    localparam logic [2:0] OP_QUERY  = 3'd1;
    localparam logic [2:0] OP_REMOVE = 3'd2;
    localparam logic [2:0] OP_CHECK  = 3'd3;
    localparam logic [2:0] OP_TOTAL  = 3'd4;
    localparam logic [2:0] OP_DUMP   = 3'd5;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    // contents of one table slot
    typedef struct packed {
        logic [31:0] sub;
        logic [15:0] svc;
        logic [63:0] up_b;
        logic [63:0] dn_b;
        logic [63:0] up_p;
        logic [63:0] dn_p;
        logic [31:0] brc;
    } t_entry;

    // search token that walks the chain of slots
    typedef struct packed {
        logic             vld;
        logic             dump;
        logic [IDX_W-1:0] start;
        logic [31:0]      sub;
        logic [15:0]      svc;
        logic             hit;
        logic [IDX_W-1:0] hidx;
        logic             more;
        logic             free;
        logic [IDX_W-1:0] fidx;
        t_entry           ent;
    } t_tok;

    // slot write broadcast from the controller
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic             vld;
        logic             load;
        t_entry           ent;
    } t_wr;

endpackage

[hw/rtl/flc_cell.sv]
// one table slot with its stage of the search token chain
module flc_cell import flc_pkg::*; #(
    parameter int IDX = 0
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_tok i_tok,
    input  t_wr  i_wr,
    output t_tok o_tok
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic   r_valid;
    t_entry r_ent;
    t_tok   r_tok;
    t_tok   n_tok;

    // slot storage, written by index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_wr.en && i_wr.idx == MY_IDX) begin
            r_valid <= i_wr.vld;
        end
        if (i_wr.en && i_wr.load && i_wr.idx == MY_IDX) begin
            r_ent <= i_wr.ent;
        end
    end

    // token update at this slot
    always_comb begin
        n_tok = i_tok;
        if (i_tok.dump) begin
            if (r_valid && MY_IDX >= i_tok.start) begin
                if (i_tok.hit) begin
                    n_tok.more = 1'b1;
                end else begin
                    n_tok.hit  = 1'b1;
                    n_tok.hidx = MY_IDX;
                    n_tok.ent  = r_ent;
                end
            end
        end else begin
            if (r_valid && r_ent.sub == i_tok.sub && r_ent.svc == i_tok.svc) begin
                n_tok.hit  = 1'b1;
                n_tok.hidx = MY_IDX;
                n_tok.ent  = r_ent;
            end
            if (!r_valid && !i_tok.free) begin
                n_tok.free = 1'b1;
                n_tok.fidx = MY_IDX;
            end
        end
    end

    // hand the token to the next slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

[hw/rtl/flc_ctrl.sv]
// operation sequencer, running total and result register
module flc_ctrl import flc_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [151:0] i_s_tdata,
    input  logic [2:0]   i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [407:0] o_m_tdata,
    output logic [1:0]   o_m_tuser,
    output logic         o_m_tlast,
    output t_tok         o_tok,
    input  t_tok         i_tail,
    output t_wr          o_wr
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_ACT  = 2'd2;

    logic [1:0]  r_state, n_state;
    logic [2:0]  r_op;
    logic [31:0] r_sub;
    logic [15:0] r_svc;
    logic [31:0] r_bytes;
    logic        r_dir;
    logic [63:0] r_thr;
    logic [63:0] r_total, n_total;
    t_tok        r_tok, n_tok;
    t_tok        r_res;
    logic        r_ov, n_ov;
    logic [1:0]  r_ostat, n_ostat;
    t_entry      r_oent, n_oent;
    logic        r_over, n_over;
    logic [63:0] r_ogt;
    logic        r_olast, n_olast;
    logic        w_fire;
    logic        w_acc;
    logic [63:0] w_sum;
    t_entry      w_ent;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_acc      = i_s_tvalid && o_s_tready;
    assign w_fire     = (r_state == S_ACT) && (!r_ov || i_m_tready);
    assign w_sum      = r_res.ent.up_b + r_res.ent.dn_b;

    // sequencing and action on the finished search
    always_comb begin
        n_state = r_state;
        n_total = r_total;
        n_tok   = '0;
        o_wr    = '0;
        n_ostat = ST_OK;
        n_oent  = '0;
        n_over  = 1'b0;
        n_olast = 1'b1;
        w_ent   = r_res.ent;
        n_ov    = r_ov && !i_m_tready;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (i_s_tuser == OP_TOTAL) begin
                        n_state = S_ACT;
                    end else if (i_s_tuser <= OP_DUMP) begin
                        n_state   = S_WALK;
                        n_tok.vld = 1'b1;
                        n_tok.dump = (i_s_tuser == OP_DUMP);
                        n_tok.sub = i_s_tdata[31:0];
                        n_tok.svc = i_s_tdata[47:32];
                    end
                end
            end
            S_WALK: begin
                if (i_tail.vld) begin
                    n_state = S_ACT;
                end
            end
            S_ACT: begin
                if (w_fire) begin
                    n_ov    = 1'b1;
                    n_state = S_IDLE;
                    n_oent.sub = r_sub;
                    n_oent.svc = r_svc;
                    case (r_op)
                        OP_UPDATE: begin
                            if (r_res.hit || r_res.free) begin
                                if (!r_res.hit) begin
                                    w_ent     = '0;
                                    w_ent.sub = r_sub;
                                    w_ent.svc = r_svc;
                                end
                                if (r_dir) begin
                                    w_ent.up_b = w_ent.up_b + {32'd0, r_bytes};
                                    w_ent.up_p = w_ent.up_p + 64'd1;
                                end else begin
                                    w_ent.dn_b = w_ent.dn_b + {32'd0, r_bytes};
                                    w_ent.dn_p = w_ent.dn_p + 64'd1;
                                end
                                o_wr.en   = 1'b1;
                                o_wr.idx  = r_res.hit ? r_res.hidx : r_res.fidx;
                                o_wr.vld  = 1'b1;
                                o_wr.load = 1'b1;
                                o_wr.ent  = w_ent;
                                n_total   = r_total + {32'd0, r_bytes};
                                n_oent    = w_ent;
                            end else begin
                                n_ostat = ST_FULL;
                            end
                        end
                        OP_QUERY: begin
                            if (r_res.hit) n_oent = r_res.ent;
                            else n_ostat = ST_NOT_FOUND;
                        end
                        OP_REMOVE: begin
                            if (r_res.hit) begin
                                o_wr.en  = 1'b1;
                                o_wr.idx = r_res.hidx;
                                n_total  = r_total - w_sum;
                                n_oent   = r_res.ent;
                            end else begin
                                n_ostat = ST_NOT_FOUND;
                            end
                        end
                        OP_CHECK: begin
                            if (r_res.hit) begin
                                if (w_sum > r_thr) begin
                                    n_over = 1'b1;
                                    if (w_ent.brc != '1) w_ent.brc = w_ent.brc + 32'd1;
                                end
                                o_wr.en   = 1'b1;
                                o_wr.idx  = r_res.hidx;
                                o_wr.vld  = 1'b1;
                                o_wr.load = 1'b1;
                                o_wr.ent  = w_ent;
                                n_oent    = w_ent;
                            end else begin
                                n_ostat = ST_NOT_FOUND;
                            end
                        end
                        OP_DUMP: begin
                            if (r_res.hit) begin
                                n_oent  = r_res.ent;
                                n_olast = !r_res.more;
                                if (r_res.more) begin
                                    n_state    = S_WALK;
                                    n_tok.vld  = 1'b1;
                                    n_tok.dump = 1'b1;
                                    n_tok.start = r_res.hidx + IDX_W'(1);
                                end
                            end else begin
                                n_ostat = ST_NOT_FOUND;
                                n_oent  = '0;
                            end
                        end
                        default: begin
                            n_oent = '0;
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_total <= '0;
            r_tok   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_total <= n_total;
            r_tok   <= n_tok;
            r_ov    <= n_ov;
        end
    end

    // captured request, search result and output payload
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_op    <= i_s_tuser;
            r_sub   <= i_s_tdata[31:0];
            r_svc   <= i_s_tdata[47:32];
            r_bytes <= i_s_tdata[79:48];
            r_dir   <= i_s_tdata[80];
            r_thr   <= i_s_tdata[144:81];
        end
        if (r_state == S_WALK && i_tail.vld) begin
            r_res <= i_tail;
        end
        if (w_fire) begin
            r_ostat <= n_ostat;
            r_oent  <= n_oent;
            r_over  <= n_over;
            r_ogt   <= n_total;
            r_olast <= n_olast;
        end
    end

    assign o_tok      = r_tok;
    assign o_m_tvalid = r_ov;
    assign o_m_tuser  = r_ostat;
    assign o_m_tlast  = r_olast;
    assign o_m_tdata  = {7'd0, r_ogt, r_over, r_oent.brc, r_oent.dn_p, r_oent.up_p,
                         r_oent.dn_b, r_oent.up_b, r_oent.svc, r_oent.sub};

endmodule

[hw/rtl/flow_usage_counter_table_top.sv]
// top level of the flow usage counter table
//
//  channel   dir  tdata (low bit up)                                   tuser    tlast
//  s_*       in   subscriber, service, byte_count, uplink_dir, thresh  op       -
//  m_*       out  sub_out, svc_out, up/down bytes, up/down packets,    status   last
//                 breach_count, over_limit, grand_total
//
// each lookup, update, remove, check or dump sends a search token down the chain
// of slots, one slot per cycle, while total usage needs no walk; each further
// dump entry costs another walk of the chain, from the slot after the last one.
// reset clears every slot's valid mark and the running total at once.
// a result waits in the output register; the next item is taken once the
// current one has been handed to that register.
module flow_usage_counter_table_top import flc_pkg::*; #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // subscriber, service, byte_count, uplink_dir, threshold, zero pad
    input  logic [151:0] i_s_tdata,
    // op
    input  logic [2:0]   i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // sub_out, svc_out, up_bytes, down_bytes, up_packets, down_packets,
    // breach_count, over_limit, grand_total, zero pad
    output logic [407:0] o_m_tdata,
    // status
    output logic [1:0]   o_m_tuser,
    output logic         o_m_tlast
);

    t_tok w_tok [0:TABLE_ENTRIES];
    t_wr  w_wr;

    flc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast),
        .o_tok      (w_tok[0]),
        .i_tail     (w_tok[TABLE_ENTRIES]),
        .o_wr       (w_wr)
    );

    // chain of slots
    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        flc_cell #(.IDX(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_tok[g]),
            .i_wr    (w_wr),
            .o_tok   (w_tok[g+1])
        );
    end

endmodule

[tb/sv/testbench.sv]
// self-checking testbench of the flow usage counter table
module testbench;
    import flc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS     = 64;
    localparam int KEY_POOL  = 80;
    localparam int HOLD_LEN  = 400;
    localparam int TAIL_WAIT = 300;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle;

    typedef struct {
        logic [2:0]  op;
        logic [31:0] sub;
        logic [15:0] svc;
        logic [31:0] bytes;
        logic        up;
        logic [63:0] thresh;
    } t_req;

    typedef struct {
        logic [1:0]  status;
        t_entry      ent;
        logic        over;
        logic [63:0] total;
        logic        last;
    } t_usage;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_valid;
    logic         o_s_tready;
    logic         o_m_tvalid;
    logic         m_ready;
    logic [407:0] o_m_tdata;
    logic [1:0]   o_m_tuser;
    logic         o_m_tlast;
    t_req         cur_req;

    // request queue, expected usage reports and the shadow table
    t_req   req_queue[$];
    t_usage usage_expected[$];
    logic   shadow_valid[SLOTS];
    t_entry shadow_entry[SLOTS];
    logic [63:0] shadow_total;

    logic [31:0] key_sub[KEY_POOL];
    logic [15:0] key_svc[KEY_POOL];
    t_idle       idle_mode;
    logic        hold_arm;
    logic        hold_taken;
    int          hold_left;
    int          err_count;
    int          report_count;
    int          full_count;
    int          dump_count;
    int          breach_count_seen;

    flow_usage_counter_table_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  ({7'd0, cur_req.thresh, cur_req.up, cur_req.bytes,
                      cur_req.svc, cur_req.sub}),
        .i_s_tuser  (cur_req.op),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_ready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // clock
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // append one request to the pending queue
    function automatic void queue_req(t_req r);
        req_queue = {req_queue, r};
    endfunction

    // append one expected usage report
    function automatic void expect_usage(t_usage u);
        usage_expected = {usage_expected, u};
    endfunction

    // random idling decision for one side
    function automatic bit idle_now(bit sender);
        int pct;
        case (idle_mode)
            IDLE_SENDER:   pct = sender ? 57 : 0;
            IDLE_RECEIVER: pct = sender ? 0 : 57;
            IDLE_BOTH:     pct = 29;
            default:       pct = 0;
        endcase
        return $urandom_range(99) < pct;
    endfunction

    function automatic int find_key(logic [31:0] sub, logic [15:0] svc);
        for (int i = 0; i < SLOTS; i++)
            if (shadow_valid[i] && shadow_entry[i].sub == sub && shadow_entry[i].svc == svc)
                return i;
        return -1;
    endfunction

    function automatic t_usage blank_usage(logic [1:0] st, logic [31:0] sub,
                                           logic [15:0] svc);
        t_usage u;
        u = '{default: '0};
        u.ent = '0;
        u.status = st;
        u.ent.sub = sub;
        u.ent.svc = svc;
        u.total = shadow_total;
        u.last = 1'b1;
        return u;
    endfunction

    function automatic t_usage slot_usage(int s, logic over, logic last);
        t_usage u;
        u.status = ST_OK;
        u.ent = shadow_entry[s];
        u.over = over;
        u.total = shadow_total;
        u.last = last;
        return u;
    endfunction

    // shadow table update and expected usage reports of one request
    function automatic void account_request(t_req r);
        int s;
        int k;
        logic over;
        case (r.op)
            OP_UPDATE: begin
                s = find_key(r.sub, r.svc);
                if (s < 0) begin
                    for (int i = SLOTS - 1; i >= 0; i--)
                        if (!shadow_valid[i]) s = i;
                    if (s >= 0) begin
                        shadow_valid[s] = 1'b1;
                        shadow_entry[s] = '0;
                        shadow_entry[s].sub = r.sub;
                        shadow_entry[s].svc = r.svc;
                    end
                end
                if (s < 0) begin
                    expect_usage(blank_usage(ST_FULL, r.sub, r.svc));
                end else begin
                    if (r.up) begin
                        shadow_entry[s].up_b += r.bytes;
                        shadow_entry[s].up_p += 1;
                    end else begin
                        shadow_entry[s].dn_b += r.bytes;
                        shadow_entry[s].dn_p += 1;
                    end
                    shadow_total += r.bytes;
                    expect_usage(slot_usage(s, 1'b0, 1'b1));
                end
            end
            OP_QUERY, OP_REMOVE, OP_CHECK: begin
                s = find_key(r.sub, r.svc);
                over = 1'b0;
                if (s < 0) begin
                    expect_usage(blank_usage(ST_NOT_FOUND, r.sub, r.svc));
                end else begin
                    if (r.op == OP_REMOVE) begin
                        shadow_total -= shadow_entry[s].up_b + shadow_entry[s].dn_b;
                        shadow_valid[s] = 1'b0;
                    end
                    if (r.op == OP_CHECK &&
                        shadow_entry[s].up_b + shadow_entry[s].dn_b > r.thresh) begin
                        over = 1'b1;
                        if (shadow_entry[s].brc != 32'hFFFF_FFFF)
                            shadow_entry[s].brc += 1;
                    end
                    expect_usage(slot_usage(s, over, 1'b1));
                end
            end
            OP_TOTAL: expect_usage(blank_usage(ST_OK, '0, '0));
            OP_DUMP: begin
                k = 0;
                for (int i = 0; i < SLOTS; i++) begin
                    if (shadow_valid[i]) begin
                        expect_usage(slot_usage(i, 1'b0, 1'b0));
                        k++;
                    end
                end
                if (k == 0)
                    expect_usage(blank_usage(ST_NOT_FOUND, '0, '0));
                else
                    usage_expected[$].last = 1'b1;
            end
            default: ;
        endcase
    endfunction

    function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
            err_count++;
        end
    endfunction

    // driver: offers queued requests, predicts each accepted transaction
    always @(posedge i_clk) begin
        t_req nxt;
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && o_s_tready)
                account_request(cur_req);
            if (!s_valid || o_s_tready) begin
                if (req_queue.size() > 0 && !idle_now(1'b1)) begin
                    nxt = req_queue.pop_front();
                    cur_req <= nxt;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, counted here
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_taken <= 1'b0;
        end else if (hold_arm && !hold_taken) begin
            hold_left <= HOLD_LEN;
            hold_taken <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // receiver ready
    always @(posedge i_clk) begin
        if (!i_rst_n)
            m_ready <= 1'b0;
        else
            m_ready <= (hold_left == 0) && !(hold_arm && !hold_taken) && !idle_now(1'b0);
    end

    // monitor: compares each report transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_usage e;
        if (i_rst_n && o_m_tvalid && m_ready) begin
            if (usage_expected.size() == 0) begin
                $error("unexpected report transaction, sub_out %0h", o_m_tdata[31:0]);
                err_count++;
            end else begin
                e = usage_expected.pop_front();
                report_count++;
                if (e.status == ST_FULL) full_count++;
                if (e.over) breach_count_seen++;
                check_field("status", e.status, o_m_tuser);
                check_field("sub_out", e.ent.sub, o_m_tdata[31:0]);
                check_field("svc_out", e.ent.svc, o_m_tdata[47:32]);
                check_field("up_bytes", e.ent.up_b, o_m_tdata[111:48]);
                check_field("down_bytes", e.ent.dn_b, o_m_tdata[175:112]);
                check_field("up_packets", e.ent.up_p, o_m_tdata[239:176]);
                check_field("down_packets", e.ent.dn_p, o_m_tdata[303:240]);
                check_field("breach_count", e.ent.brc, o_m_tdata[335:304]);
                check_field("over_limit", e.over, o_m_tdata[336]);
                check_field("grand_total", e.total, o_m_tdata[400:337]);
                check_field("pad", 64'd0, o_m_tdata[407:401]);
                check_field("last", e.last, o_m_tlast);
            end
        end
    end

    function automatic t_req make_req(logic [2:0] op, int key, logic [31:0] bytes,
                                      logic up, logic [63:0] thresh);
        t_req r;
        r.op = op;
        r.sub = key_sub[key];
        r.svc = key_svc[key];
        r.bytes = bytes;
        r.up = up;
        r.thresh = thresh;
        return r;
    endfunction

    // random request, half of them updates, over a key pool a bit larger than the table
    function automatic t_req random_req();
        int w;
        int key;
        logic [2:0] op;
        logic [63:0] thr;
        w = $urandom_range(99);
        key = $urandom_range(KEY_POOL - 1);
        if (w < 50)      op = OP_UPDATE;
        else if (w < 62) op = OP_QUERY;
        else if (w < 72) op = OP_REMOVE;
        else if (w < 87) op = OP_CHECK;
        else if (w < 92) op = OP_TOTAL;
        else if (w < 95) op = OP_DUMP;
        else             op = 3'($urandom_range(6, 7));
        case ($urandom_range(3))
            0:       thr = {$urandom, $urandom};
            1:       thr = {32'd0, $urandom};
            2:       thr = {31'd0, $urandom, 1'b0};
            default: thr = 64'($urandom_range(1000));
        endcase
        if (op == OP_DUMP) dump_count++;
        return make_req(op, key, $urandom, 1'($urandom_range(1)), thr);
    endfunction

    task automatic wait_idle();
        while (req_queue.size() > 0 || s_valid || usage_expected.size() > 0)
            @(posedge i_clk);
    endtask

    // stimulus sequence
    initial begin
        idle_mode = IDLE_NONE;
        hold_arm = 1'b0;
        err_count = 0;
        report_count = 0;
        full_count = 0;
        dump_count = 0;
        breach_count_seen = 0;
        cur_req = '{default: '0};
        shadow_total = '0;
        for (int i = 0; i < SLOTS; i++) begin
            shadow_valid[i] = 1'b0;
            shadow_entry[i] = '0;
        end
        for (int i = 0; i < KEY_POOL; i++) begin
            key_sub[i] = $urandom;
            key_svc[i] = 16'($urandom);
        end
        key_sub[0] = 32'd0;
        key_svc[0] = 16'd0;
        key_sub[1] = 32'hFFFF_FFFF;
        key_svc[1] = 16'hFFFF;
        // same subscriber, different service must be a separate flow
        key_sub[2] = 32'hFFFF_FFFF;
        key_svc[2] = 16'd0;
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty dump, extremes, hits and misses, unused codes
        queue_req(make_req(OP_DUMP, 0, 0, 0, 0));
        queue_req(make_req(OP_QUERY, 0, 0, 0, 0));
        queue_req(make_req(OP_UPDATE, 0, 32'd0, 1'b0, 0));
        queue_req(make_req(OP_UPDATE, 1, 32'hFFFF_FFFF, 1'b1, 0));
        queue_req(make_req(OP_UPDATE, 1, 32'hFFFF_FFFF, 1'b1, 0));
        queue_req(make_req(OP_UPDATE, 1, 32'h1234_5678, 1'b0, 0));
        queue_req(make_req(OP_UPDATE, 2, 32'h8000_0001, 1'b0, 0));
        queue_req(make_req(OP_QUERY, 1, 0, 0, 0));
        queue_req(make_req(OP_QUERY, 3, 0, 0, 0));
        queue_req(make_req(OP_CHECK, 1, 0, 0, 64'd0));
        queue_req(make_req(OP_CHECK, 1, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF));
        queue_req(make_req(OP_CHECK, 0, 0, 0, 64'd0));
        queue_req(make_req(OP_CHECK, 3, 0, 0, 64'd0));
        queue_req(make_req(OP_TOTAL, 3, 0, 0, 0));
        queue_req(make_req(3'd6, 1, 32'hFFFF_FFFF, 1'b1, 0));
        queue_req(make_req(3'd7, 1, 32'hFFFF_FFFF, 1'b1, 0));
        queue_req(make_req(OP_DUMP, 0, 0, 0, 0));
        queue_req(make_req(OP_REMOVE, 3, 0, 0, 0));
        queue_req(make_req(OP_REMOVE, 0, 0, 0, 0));
        queue_req(make_req(OP_UPDATE, 3, 32'd77, 1'b1, 0));
        queue_req(make_req(OP_DUMP, 0, 0, 0, 0));
        queue_req(make_req(OP_TOTAL, 0, 0, 0, 0));
        wait_idle();

        // fill the table past capacity with distinct keys
        idle_mode = IDLE_SENDER;
        for (int i = 0; i < 70; i++)
            queue_req(make_req(OP_UPDATE, i, $urandom, 1'($urandom_range(1)), 0));
        queue_req(make_req(OP_DUMP, 0, 0, 0, 0));
        wait_idle();

        // receiver holds off while requests keep coming
        idle_mode = IDLE_NONE;
        hold_arm = 1'b1;
        for (int i = 0; i < 60; i++) queue_req(random_req());
        // sender pauses until every report is back
        wait_idle();

        idle_mode = IDLE_RECEIVER;
        for (int i = 0; i < 70; i++) queue_req(random_req());
        wait_idle();
        idle_mode = IDLE_BOTH;
        for (int i = 0; i < 70; i++) queue_req(random_req());
        wait_idle();
        idle_mode = IDLE_SENDER;
        for (int i = 0; i < 50; i++) queue_req(random_req());
        wait_idle();

        repeat (TAIL_WAIT) @(posedge i_clk);
        $display("covered %0d reports: %0d table-full, %0d over-limit, %0d random dumps",
                 report_count, full_count, breach_count_seen, dump_count);
        $display("with a full table, a long receiver hold-off and four idling phases");
        if (err_count == 0 && usage_expected.size() == 0) begin
            $display("flow_usage_counter_table_top regression: pass");
        end else begin
            $display("flow_usage_counter_table_top regression: fail");
        end
        $finish;
    end

    // run limit
    initial begin
        #30ms;
        $display("timeout with %0d reports outstanding", usage_expected.size());
        $display("flow_usage_counter_table_top regression: fail");
        $finish;
    end

endmodule

[files.f]
hw/rtl/flc_pkg.sv
hw/rtl/flc_cell.sv
hw/rtl/flc_ctrl.sv
hw/rtl/flow_usage_counter_table_top.sv
tb/sv/testbench.sv
